@@ hw/rtl/sync_framed_packet_deframer_defines.svh @@
// Assertion macros used by the deframer's frame parser.
`ifndef SYNC_FRAMED_PACKET_DEFRAMER_DEFINES_SVH
`define SYNC_FRAMED_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sfpd_pkg.sv @@
// Types and constants for the sync framed packet deframer.
`timescale 1ns / 1ps

package sfpd_pkg;

    localparam int MAX_LEN_DEFAULT = 31;
    localparam int WIDTH_LIMIT     = 31;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_THIRD      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FOURTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REJECT_LOOPBACK = 3'd5;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_FROM    = 4'd2,
        PH_TO      = 4'd3,
        PH_LEN     = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CRC_LO  = 4'd6,
        PH_CRC_HI  = 4'd7,
        PH_SYNC3   = 4'd8,
        PH_SYNC4   = 4'd9
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD  = 1'b0,
        KIND_COMPLETE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       transmitting;
    } in_t;

    typedef struct packed {
        logic [0:0]  result_kind;
        logic [7:0]  data_byte;
        logic [4:0]  byte_index;
        logic [7:0]  source_address;
        logic [4:0]  frame_length;
        logic [15:0] received_crc;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] sync_third;
        logic [7:0] sync_fourth;
        logic [7:0] own_address;
        logic       reject_loopback;
    } cfg_t;

endpackage

@@ hw/rtl/sfpd_parser.sv @@
// Frame parser: phase state, header/CRC capture and result generation.
`timescale 1ns / 1ps
`include "sync_framed_packet_deframer_defines.svh"

module sfpd_parser #(
    parameter int MAX_LEN = sfpd_pkg::MAX_LEN_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  sfpd_pkg::in_t  item,
    input  sfpd_pkg::cfg_t cfg,
    output logic          res_valid,
    output sfpd_pkg::out_t res
);

    localparam logic [7:0] LEN_LIMIT = 8'((MAX_LEN < sfpd_pkg::WIDTH_LIMIT) ?
                                          MAX_LEN : sfpd_pkg::WIDTH_LIMIT);

    sfpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  held_source_reg, held_source_next;
    logic [4:0]  held_length_reg, held_length_next;
    logic [5:0]  byte_count_reg, byte_count_next;
    logic [15:0] held_crc_reg, held_crc_next;

    logic       ignore;
    logic       live;
    logic [7:0] b;
    logic [5:0] count_inc;

    assign b         = item.rx_byte;
    assign ignore    = cfg.reject_loopback & item.transmitting;
    assign live      = step & ~ignore;
    assign count_inc = byte_count_reg + 6'd1;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        held_source_next = held_source_reg;
        held_length_next = held_length_reg;
        byte_count_next  = byte_count_reg;
        held_crc_next    = held_crc_reg;
        if (live)
        begin
            unique case (phase_reg)
                sfpd_pkg::PH_SYNC2:
                    phase_next = (b == cfg.sync_second) ? sfpd_pkg::PH_FROM
                                                        : sfpd_pkg::PH_HUNT;
                sfpd_pkg::PH_FROM:
                begin
                    held_source_next = b;
                    phase_next       = sfpd_pkg::PH_TO;
                end
                sfpd_pkg::PH_TO:
                    phase_next = (b == sfpd_pkg::BROADCAST_ADDR || b == cfg.own_address) ?
                                 sfpd_pkg::PH_LEN : sfpd_pkg::PH_HUNT;
                sfpd_pkg::PH_LEN:
                begin
                    byte_count_next = 6'd0;
                    if (b > LEN_LIMIT)
                    begin
                        held_length_next = 5'd0;
                        phase_next       = sfpd_pkg::PH_HUNT;
                    end
                    else
                    begin
                        held_length_next = b[4:0];
                        phase_next = (b == 8'd0) ? sfpd_pkg::PH_CRC_LO
                                                 : sfpd_pkg::PH_PAYLOAD;
                    end
                end
                sfpd_pkg::PH_PAYLOAD:
                begin
                    byte_count_next = count_inc;
                    if (count_inc >= {1'b0, held_length_reg})
                        phase_next = sfpd_pkg::PH_CRC_LO;
                end
                sfpd_pkg::PH_CRC_LO:
                begin
                    held_crc_next = {8'd0, b};
                    phase_next    = sfpd_pkg::PH_CRC_HI;
                end
                sfpd_pkg::PH_CRC_HI:
                begin
                    held_crc_next = {b, held_crc_reg[7:0]};
                    phase_next    = sfpd_pkg::PH_SYNC3;
                end
                sfpd_pkg::PH_SYNC3:
                    phase_next = (b == cfg.sync_third) ? sfpd_pkg::PH_SYNC4
                                                       : sfpd_pkg::PH_HUNT;
                sfpd_pkg::PH_SYNC4:
                    phase_next = sfpd_pkg::PH_HUNT;
                default:
                    phase_next = (b == cfg.sync_first) ? sfpd_pkg::PH_SYNC2
                                                       : sfpd_pkg::PH_HUNT;
            endcase
        end
    end

    // results
    always_comb
    begin
        res_valid          = 1'b0;
        res.result_kind    = sfpd_pkg::KIND_PAYLOAD;
        res.data_byte      = 8'd0;
        res.byte_index     = 5'd0;
        res.source_address = held_source_reg;
        res.frame_length   = held_length_reg;
        res.received_crc   = 16'd0;
        res.last           = 1'b0;
        if (live && phase_reg == sfpd_pkg::PH_PAYLOAD)
        begin
            res_valid      = 1'b1;
            res.data_byte  = b;
            res.byte_index = byte_count_reg[4:0];
        end
        else if (live && phase_reg == sfpd_pkg::PH_SYNC4 && b == cfg.sync_fourth)
        begin
            res_valid        = 1'b1;
            res.result_kind  = sfpd_pkg::KIND_COMPLETE;
            res.received_crc = held_crc_reg;
            res.last         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= sfpd_pkg::PH_HUNT;
            held_source_reg <= 8'd0;
            held_length_reg <= 5'd0;
            byte_count_reg  <= 6'd0;
            held_crc_reg    <= 16'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_source_reg <= held_source_next;
            held_length_reg <= held_length_next;
            byte_count_reg  <= byte_count_next;
            held_crc_reg    <= held_crc_next;
        end
    end

    `SFPD_ASSERT_NOW(a_payload_in_phase, clk, rst_n,
        res_valid && res.result_kind == sfpd_pkg::KIND_PAYLOAD,
        phase_reg == sfpd_pkg::PH_PAYLOAD && step,
        "payload request outside payload phase")
    `SFPD_ASSERT_NOW(a_index_in_range, clk, rst_n,
        res_valid && res.result_kind == sfpd_pkg::KIND_PAYLOAD,
        res.byte_index < res.frame_length,
        "payload index beyond frame length")
    `SFPD_ASSERT_NEXT(a_zero_len_to_crc, clk, rst_n,
        live && phase_reg == sfpd_pkg::PH_LEN && b == 8'd0,
        phase_reg == sfpd_pkg::PH_CRC_LO,
        "zero length did not go to CRC capture")
    `SFPD_ASSERT_NEXT(a_loopback_holds, clk, rst_n,
        step && ignore,
        $stable(phase_reg) && $stable(byte_count_reg),
        "rejected loopback byte changed parser state")

endmodule

@@ hw/rtl/sync_framed_packet_deframer.sv @@
// Top level of the sync framed packet deframer.
//
//   channel | dir | payload            | handshake
//   in      | in  | sfpd_pkg::in_t     | in_valid / in_stall
//   out     | out | sfpd_pkg::out_t    | out_valid / out_stall
//   cfg     | in  | cfg_index/cfg_data | cfg_we, no wait
//
// One byte per cycle sustained while the output is not stalled; a byte's result passes
// through the input register, the parser and the result register.
// Reset clears the config registers, the parser state and both valid flags.
// in_stall rises only while the input register holds a byte and the result
// register is full and stalled; otherwise a byte is taken every cycle.
`timescale 1ns / 1ps

module sync_framed_packet_deframer #(
    parameter int MAX_LEN = sfpd_pkg::MAX_LEN_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  sfpd_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output sfpd_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [sfpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sfpd_pkg::cfg_t cfg_reg;
    sfpd_pkg::in_t  item_reg;
    logic           item_valid_reg;
    sfpd_pkg::out_t out_data_reg;
    logic           out_valid_reg;

    logic           out_free;
    logic           step;
    logic           res_valid;
    sfpd_pkg::out_t res;

    assign out_free  = ~out_valid_reg | ~out_stall;
    assign step      = item_valid_reg & out_free;
    assign in_stall  = item_valid_reg & ~out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    sfpd_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfpd_pkg::CFG_SYNC_FIRST:      cfg_reg.sync_first      <= cfg_data;
                sfpd_pkg::CFG_SYNC_SECOND:     cfg_reg.sync_second     <= cfg_data;
                sfpd_pkg::CFG_SYNC_THIRD:      cfg_reg.sync_third      <= cfg_data;
                sfpd_pkg::CFG_SYNC_FOURTH:     cfg_reg.sync_fourth     <= cfg_data;
                sfpd_pkg::CFG_OWN_ADDRESS:     cfg_reg.own_address     <= cfg_data;
                sfpd_pkg::CFG_REJECT_LOOPBACK: cfg_reg.reject_loopback <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                item_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= step & res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
        if (step && res_valid)
            out_data_reg <= res;
    end

endmodule

@@ dv/sync_framed_packet_deframer_tb.sv @@
// Self-checking testbench for the sync framed packet deframer, with its own frame parser model.
`timescale 1ns / 1ps

module sync_framed_packet_deframer_tb;

    localparam int PIPE_DRAIN  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    localparam logic [sfpd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [sfpd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_B = 3'd7;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    sfpd_pkg::in_t                    in_data;
    logic                             out_valid;
    logic                             out_stall;
    sfpd_pkg::out_t                   out_data;
    logic                             cfg_we;
    logic [sfpd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sfpd_pkg::CFG_DATA_W-1:0]  cfg_data;

    sync_framed_packet_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // parser model
    sfpd_pkg::cfg_t   shadow_cfg;
    sfpd_pkg::phase_t rx_phase;
    logic [7:0]       frm_source;
    logic [4:0]       frm_length;
    logic [5:0]       frm_count;
    logic [15:0]      frm_crc;

    sfpd_pkg::out_t   expected_results[$];
    logic [7:0]       frame_buf[$];

    int          err_count;
    int          cycle_count;
    int          requests_taken;
    int          hold_request;
    int          stall_left;
    bit          send_idle_on;
    bit          recv_idle_on;

    function automatic void deframe_byte(sfpd_pkg::in_t req);
        sfpd_pkg::out_t res;
        bit             has_result;
        int             len_limit;
        len_limit  = (sfpd_pkg::MAX_LEN_DEFAULT < sfpd_pkg::WIDTH_LIMIT) ?
                     sfpd_pkg::MAX_LEN_DEFAULT : sfpd_pkg::WIDTH_LIMIT;
        has_result = 1'b0;
        res        = '0;
        if (shadow_cfg.reject_loopback && req.transmitting)
            return;
        case (rx_phase)
            sfpd_pkg::PH_SYNC2:
                rx_phase = (req.rx_byte == shadow_cfg.sync_second) ? sfpd_pkg::PH_FROM
                                                                   : sfpd_pkg::PH_HUNT;
            sfpd_pkg::PH_FROM:
            begin
                frm_source = req.rx_byte;
                rx_phase   = sfpd_pkg::PH_TO;
            end
            sfpd_pkg::PH_TO:
                rx_phase = (req.rx_byte == sfpd_pkg::BROADCAST_ADDR ||
                            req.rx_byte == shadow_cfg.own_address)
                           ? sfpd_pkg::PH_LEN : sfpd_pkg::PH_HUNT;
            sfpd_pkg::PH_LEN:
            begin
                frm_count = '0;
                if (req.rx_byte > len_limit)
                begin
                    frm_length = '0;
                    rx_phase   = sfpd_pkg::PH_HUNT;
                end
                else
                begin
                    frm_length = req.rx_byte[4:0];
                    rx_phase   = (req.rx_byte == 8'd0) ? sfpd_pkg::PH_CRC_LO
                                                       : sfpd_pkg::PH_PAYLOAD;
                end
            end
            sfpd_pkg::PH_PAYLOAD:
            begin
                res.result_kind = sfpd_pkg::KIND_PAYLOAD;
                res.data_byte   = req.rx_byte;
                res.byte_index  = frm_count[4:0];
                frm_count       = frm_count + 6'd1;
                if (frm_count >= frm_length)
                    rx_phase = sfpd_pkg::PH_CRC_LO;
                has_result = 1'b1;
            end
            sfpd_pkg::PH_CRC_LO:
            begin
                frm_crc  = {8'h00, req.rx_byte};
                rx_phase = sfpd_pkg::PH_CRC_HI;
            end
            sfpd_pkg::PH_CRC_HI:
            begin
                frm_crc  = {req.rx_byte, frm_crc[7:0]};
                rx_phase = sfpd_pkg::PH_SYNC3;
            end
            sfpd_pkg::PH_SYNC3:
                rx_phase = (req.rx_byte == shadow_cfg.sync_third) ? sfpd_pkg::PH_SYNC4
                                                                  : sfpd_pkg::PH_HUNT;
            sfpd_pkg::PH_SYNC4:
            begin
                rx_phase = sfpd_pkg::PH_HUNT;
                if (req.rx_byte == shadow_cfg.sync_fourth)
                begin
                    res.result_kind  = sfpd_pkg::KIND_COMPLETE;
                    res.received_crc = frm_crc;
                    res.last         = 1'b1;
                    has_result       = 1'b1;
                end
            end
            default:
                rx_phase = (req.rx_byte == shadow_cfg.sync_first) ? sfpd_pkg::PH_SYNC2
                                                                  : sfpd_pkg::PH_HUNT;
        endcase
        if (has_result)
        begin
            res.source_address = frm_source;
            res.frame_length   = frm_length;
            expected_results.push_back(res);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            err_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin : result_check
        sfpd_pkg::out_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: 0x%0h", out_data);
                err_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                check_field("result_kind", 16'(exp_res.result_kind),
                            16'(out_data.result_kind));
                check_field("data_byte", 16'(exp_res.data_byte), 16'(out_data.data_byte));
                check_field("byte_index", 16'(exp_res.byte_index), 16'(out_data.byte_index));
                check_field("source_address", 16'(exp_res.source_address),
                            16'(out_data.source_address));
                check_field("frame_length", 16'(exp_res.frame_length),
                            16'(out_data.frame_length));
                check_field("received_crc", exp_res.received_crc, out_data.received_crc);
                check_field("last", 16'(exp_res.last), 16'(out_data.last));
            end
        end
    end

    // receiver stalls: random bursts, or one long hold on request
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (hold_request > 0)
        begin
            out_stall    <= 1'b1;
            stall_left   = hold_request - 1;
            hold_request = 0;
        end
        else if (recv_idle_on && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sync_framed_packet_deframer regression: fail");
            $finish;
        end
    end

    task automatic send_request(input logic [7:0] rx_val, input logic tx_val);
        sfpd_pkg::in_t req;
        int            gap;
        req.rx_byte      = rx_val;
        req.transmitting = tx_val;
        gap = 0;
        if (send_idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        deframe_byte(req);
        requests_taken++;
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        stop_input();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sfpd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            sfpd_pkg::CFG_SYNC_FIRST:      shadow_cfg.sync_first      = val;
            sfpd_pkg::CFG_SYNC_SECOND:     shadow_cfg.sync_second     = val;
            sfpd_pkg::CFG_SYNC_THIRD:      shadow_cfg.sync_third      = val;
            sfpd_pkg::CFG_SYNC_FOURTH:     shadow_cfg.sync_fourth     = val;
            sfpd_pkg::CFG_OWN_ADDRESS:     shadow_cfg.own_address     = val;
            sfpd_pkg::CFG_REJECT_LOOPBACK: shadow_cfg.reject_loopback = val[0];
            default: ;
        endcase
    endtask

    task automatic program_cfg(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3,
                               input logic [7:0] s4, input logic [7:0] own,
                               input logic [7:0] loopback);
        wait_idle();
        write_reg(sfpd_pkg::CFG_SYNC_FIRST, s1);
        write_reg(sfpd_pkg::CFG_SYNC_SECOND, s2);
        write_reg(sfpd_pkg::CFG_SYNC_THIRD, s3);
        write_reg(sfpd_pkg::CFG_SYNC_FOURTH, s4);
        write_reg(sfpd_pkg::CFG_OWN_ADDRESS, own);
        write_reg(sfpd_pkg::CFG_REJECT_LOOPBACK, loopback);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                      8'($urandom_range(0, 255)));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_cfg();
        program_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // noisy: random transmitting flag when rejection is off, ignored echo bytes when it is on
    task automatic send_buf(input bit noisy);
        logic tx;
        foreach (frame_buf[i])
        begin
            tx = 1'b0;
            if (noisy)
            begin
                if (shadow_cfg.reject_loopback && $urandom_range(0, 9) == 0)
                    send_request(8'($urandom_range(0, 255)), 1'b1);
                if (!shadow_cfg.reject_loopback)
                    tx = ($urandom_range(0, 7) == 0);
            end
            send_request(frame_buf[i], tx);
        end
    endtask

    task automatic random_frame();
        int         len;
        int         pick;
        int         pos;
        logic [7:0] dest;
        pick = $urandom_range(0, 19);
        len  = (pick == 0) ? $urandom_range(32, 255) : $urandom_range(0, 31);
        pick = $urandom_range(0, 9);
        dest = (pick < 5) ? shadow_cfg.own_address :
               (pick < 8) ? sfpd_pkg::BROADCAST_ADDR : 8'($urandom_range(0, 255));
        frame_buf = {shadow_cfg.sync_first, shadow_cfg.sync_second,
                     8'($urandom_range(0, 255)), dest, 8'(len)};
        if (len <= sfpd_pkg::WIDTH_LIMIT)
        begin
            repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
            frame_buf.push_back(8'($urandom_range(0, 255)));
            frame_buf.push_back(8'($urandom_range(0, 255)));
            frame_buf.push_back(shadow_cfg.sync_third);
            frame_buf.push_back(shadow_cfg.sync_fourth);
        end
        pick = $urandom_range(0, 9);
        pos  = $urandom_range(0, frame_buf.size() - 1);
        if (pick == 0)
            frame_buf[pos] = 8'($urandom_range(0, 255));
        else if (pick == 1)
            while (frame_buf.size() > pos)
                void'(frame_buf.pop_back());
        else if (pick == 2)
            repeat ($urandom_range(1, 6)) frame_buf.push_front(8'($urandom_range(0, 255)));
        send_buf(1'b1);
    endtask

    task automatic random_phase(input int n);
        int target;
        target = requests_taken + n;
        while (requests_taken < target)
            random_frame();
    endtask

    task automatic test_directed();
        program_cfg(8'h7E, 8'h81, 8'hA5, 8'h5A, 8'h12, 8'h01);
        // zero length, with an echoed byte in the header
        frame_buf = {8'h7E, 8'h81, 8'h00, 8'h12};
        send_buf(1'b0);
        send_request(8'hFF, 1'b1);
        frame_buf = {8'h00, 8'h34, 8'h12, 8'hA5, 8'h5A};
        send_buf(1'b0);
        // broadcast, extreme bytes
        frame_buf = {8'h7E, 8'h81, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hA5, 8'h5A};
        send_buf(1'b0);
        // length over the limit
        frame_buf = {8'h7E, 8'h81, 8'h01, 8'h12, 8'h20};
        send_buf(1'b0);
    endtask

    task automatic test_cfg_extremes();
        program_cfg(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        random_phase(150);
        program_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_phase(150);
    endtask

    task automatic test_random_cfgs();
        repeat (4)
        begin
            random_cfg();
            random_phase(150);
        end
    endtask

    task automatic test_backpressure();
        random_cfg();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_request = LONG_HOLD;
        random_phase(120);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        random_phase(100);
        stop_input();
        while (expected_results.size() != 0)
            @(posedge clk);
        random_phase(100);
    endtask

    task automatic test_no_idle();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        random_cfg();
        random_phase(200);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        err_count      = 0;
        cycle_count    = 0;
        requests_taken = 0;
        hold_request   = 0;
        stall_left     = 0;
        send_idle_on   = 1'b1;
        recv_idle_on   = 1'b1;
        shadow_cfg     = '0;
        rx_phase       = sfpd_pkg::PH_HUNT;
        frm_source     = '0;
        frm_length     = '0;
        frm_count      = '0;
        frm_crc        = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_cfg_extremes();
        test_random_cfgs();
        test_backpressure();
        test_sender_pause();
        test_no_idle();

        wait_idle();
        repeat (PIPE_DRAIN) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("sync_framed_packet_deframer regression: pass");
        else
            $display("sync_framed_packet_deframer regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sfpd_pkg.sv
hw/rtl/sfpd_parser.sv
hw/rtl/sync_framed_packet_deframer.sv
dv/sync_framed_packet_deframer_tb.sv
